>>> hdl/assert_macros.svh
// Assertion macros used by the checker module of the bitrate meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SWBM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SWBM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/swbm_pkg.sv
// Shared constants, command and status types of the sliding window bitrate meter.
`timescale 1ns / 1ps

package swbm_pkg;

  localparam int MAX_BUCKETS_DEF = 16;
  localparam int BITS_PER_BYTE   = 8;
  localparam int RATE_DIVISOR    = 1000;

  localparam int TIME_W    = 32;
  localparam int BYTE_IN_W = 32;
  localparam int BYTES_W   = 40;
  localparam int RATE_W    = 32;
  localparam int WIN_W     = 5;
  localparam int WIN_RESET = 8;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;

  // Rate divider: numerator is the byte total in bits, denominator the
  // elapsed seconds scaled to kilobits.
  localparam int NUM_SHIFT  = $clog2(BITS_PER_BYTE);
  localparam int NUM_W      = BYTES_W + NUM_SHIFT;
  localparam int DIV_MUL_W  = $clog2(RATE_DIVISOR + 1);
  localparam int DEN_W      = TIME_W + DIV_MUL_W;
  localparam int DIV_STEPS  = NUM_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_SEL_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_SEL_W-1:0] REG_WINDOW_SECONDS = CFG_SEL_W'(0);

  typedef struct packed {
    logic load;       // latch the input beat, read the newest bucket
    logic check;      // time check, window clear, total update, merge
    logic insert;     // open a new bucket, dropping the oldest if full
    logic exp_eval;   // expire the oldest bucket or fix the window start
    logic div_init;   // load numerator and denominator of the divider
    logic div_step;   // one restoring divide step
    logic out_load;   // capture the result into the output register
  } swbm_cmd_t;

  typedef struct packed {
    logic merge;      // bytes go into the newest bucket
    logic expire;     // oldest bucket has aged out
    logic rate_zero;  // now is not past the window start
  } swbm_status_t;

endpackage

>>> hdl/swbm_datapath.sv
// Datapath of the bitrate meter: bucket ring memory, window registers and serial divider.
`timescale 1ns / 1ps

module swbm_datapath import swbm_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swbm_cmd_t            cmd,
  output swbm_status_t         status,
  input  logic [TIME_W-1:0]    now_seconds,
  input  logic [BYTE_IN_W-1:0] byte_count,
  input  logic [WIN_W-1:0]     window_seconds,
  output logic [RATE_W-1:0]    rate_kbps,
  output logic [BYTES_W-1:0]   window_bytes
);

  localparam int IDX_W   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CNT_W   = $clog2(MAX_BUCKETS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ENTRY_W = TIME_W + BYTES_W;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(MAX_BUCKETS)) begin
      sum = sum - SUM_W'(MAX_BUCKETS);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
  endfunction

  function automatic logic [BYTES_W-1:0] floor_sub(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

  logic [ENTRY_W-1:0]   bucket_mem [MAX_BUCKETS];
  logic [ENTRY_W-1:0]   rd_entry_r;

  logic [TIME_W-1:0]    now_r;
  logic [BYTES_W-1:0]   bytes_r;
  logic [IDX_W-1:0]     oldest_r, oldest_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [BYTES_W-1:0]   total_r, total_nxt;
  logic [TIME_W-1:0]    start_r, start_nxt;

  logic [NUM_W-1:0]     num_r;
  logic [DEN_W:0]       rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [RATE_W-1:0]    rate_out_r;
  logic [BYTES_W-1:0]   bytes_out_r;

  logic [IDX_W-1:0]     newest_idx, tail_idx, oldest_inc, rd_addr, wr_addr;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   wr_data;
  logic [TIME_W-1:0]    rd_sec, age;
  logic [BYTES_W-1:0]   rd_bytes, total_base;
  logic                 has_bucket, full, clear;
  logic [DEN_W:0]       rem_sh;
  logic                 rem_ge;

  assign rd_sec     = rd_entry_r[ENTRY_W-1 -: TIME_W];
  assign rd_bytes   = rd_entry_r[BYTES_W-1:0];
  assign has_bucket = (count_r != '0);
  assign full       = (count_r == CNT_W'(MAX_BUCKETS));
  assign newest_idx = has_bucket ? slot_of(oldest_r, count_r - CNT_W'(1)) : oldest_r;
  assign tail_idx   = slot_of(oldest_r, count_r);
  assign oldest_inc = slot_of(oldest_r, CNT_W'(1));
  assign rd_addr    = cmd.load ? newest_idx : oldest_r;

  // Time running backwards against the window start or the newest bucket.
  assign clear      = (now_r < start_r) || (has_bucket && (now_r < rd_sec));
  assign age        = now_r - rd_sec;
  assign total_base = clear ? '0 : total_r;

  assign status.merge     = !clear && has_bucket && (rd_sec == now_r);
  assign status.expire    = has_bucket && (age >= TIME_W'(window_seconds));
  assign status.rate_zero = !(now_r > start_r);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    start_nxt  = start_r;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    wr_data    = {now_r, bytes_r};
    if (cmd.check) begin
      if (clear) begin
        oldest_nxt = '0;
        count_nxt  = '0;
        start_nxt  = now_r;
      end
      total_nxt = sat_add(total_base, bytes_r);
      if (status.merge) begin
        wr_en   = 1'b1;
        wr_addr = newest_idx;
        wr_data = {now_r, sat_add(rd_bytes, bytes_r)};
      end
    end
    if (cmd.insert) begin
      wr_en = 1'b1;
      if (full) begin
        total_nxt  = floor_sub(total_r, rd_bytes);
        oldest_nxt = oldest_inc;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
    if (cmd.exp_eval) begin
      if (status.expire) begin
        total_nxt  = floor_sub(total_r, rd_bytes);
        oldest_nxt = oldest_inc;
        count_nxt  = count_r - CNT_W'(1);
      end else if (has_bucket) begin
        start_nxt = rd_sec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
      total_r  <= '0;
      start_r  <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      start_r  <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      bucket_mem[wr_addr] <= wr_data;
    end
    rd_entry_r <= bucket_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r   <= now_seconds;
      bytes_r <= BYTES_W'(byte_count);
    end
  end

  assign rem_sh = {rem_r[DEN_W-1:0], num_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_r <= DEN_W'(now_r - start_r) * DEN_W'(RATE_DIVISOR);
      num_r <= NUM_W'(total_r) << NUM_SHIFT;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[NUM_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (status.rate_zero) begin
        rate_out_r <= '0;
      end else if (|num_r[NUM_W-1:RATE_W]) begin
        rate_out_r <= {RATE_W{1'b1}};
      end else begin
        rate_out_r <= num_r[RATE_W-1:0];
      end
      bytes_out_r <= total_r;
    end
  end

  assign rate_kbps    = rate_out_r;
  assign window_bytes = bytes_out_r;

endmodule

>>> hdl/swbm_ctrl.sv
// Controller of the bitrate meter: sequences one beat through check, expiry and divide.
`timescale 1ns / 1ps

module swbm_ctrl import swbm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  swbm_status_t status,
  output swbm_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_INSERT   = 3'd2;
  localparam logic [2:0] S_EXP_RD   = 3'd3;
  localparam logic [2:0] S_EXP_EVAL = 3'd4;
  localparam logic [2:0] S_SETUP    = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]           state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_tready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.merge ? S_EXP_RD : S_INSERT;
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = S_EXP_RD;
      end
      S_EXP_RD: begin
        state_nxt = S_EXP_EVAL;
      end
      S_EXP_EVAL: begin
        cmd.exp_eval = 1'b1;
        state_nxt    = status.expire ? S_EXP_RD : S_SETUP;
      end
      S_SETUP: begin
        cmd.div_init = 1'b1;
        div_cnt_nxt  = '0;
        state_nxt    = status.rate_zero ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hdl/sliding_window_bitrate_meter.sv
// Top level of the sliding window bitrate meter with its configuration register.
// A beat accepted passes through check, insert (skipped on a merge), the expiry walk, setup
// and the divide (skipped when the rate is 0), then waits until the output register is free.
// One beat at a time: the 43-step restoring divider and the expiry walk over the bucket
// memory, whose read is registered, set the period between beats.
// Reset (synchronous, rst_n low) empties the window and sets window_seconds to 8;
// the bucket memory is not cleared, no entry is read before it is written.
`timescale 1ns / 1ps

module sliding_window_bitrate_meter import swbm_pkg::*; #(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,    // [31:0] now_seconds, [63:32] byte_count
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [31:0] rate_kbps, [71:32] window_bytes
  // Configuration port.
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // The register file holds one register, window_seconds, at byte address 0.
  // The two low address bits select a byte within the word and are ignored.
  logic [WIN_W-1:0] window_seconds_r, window_seconds_nxt;
  logic             cfg_hit;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SECONDS);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;

  always_comb begin
    window_seconds_nxt = window_seconds_r;
    if (cfg_wr) begin
      window_seconds_nxt = cfg_pwdata[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_seconds_r <= WIN_W'(WIN_RESET);
    end else begin
      window_seconds_r <= window_seconds_nxt;
    end
  end

  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(window_seconds_r) : '0;

  // The controller walks each beat through the following steps:
  //   check    - detect time going backwards, add the bytes to the total and
  //              merge them into the newest bucket when it has the same second,
  //   insert   - otherwise open a bucket, dropping the oldest one if the ring is full,
  //   expiry   - read the oldest bucket and drop it while it has aged out; the
  //              first surviving bucket sets the window start,
  //   divide   - total*8 over (now-start)*1000, one quotient bit per cycle, skipped when the rate is 0,
  //   done     - hand the result to the output register once it is free.
  // The output register lets a new beat enter while the previous result waits.
  swbm_cmd_t    cmd;
  swbm_status_t status;

  swbm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  logic [RATE_W-1:0]  rate_kbps;
  logic [BYTES_W-1:0] window_bytes;

  swbm_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .now_seconds    (in_tdata[TIME_W-1:0]),
    .byte_count     (in_tdata[TIME_W +: BYTE_IN_W]),
    .window_seconds (window_seconds_r),
    .rate_kbps      (rate_kbps),
    .window_bytes   (window_bytes)
  );

  assign out_tdata = {window_bytes, rate_kbps};

endmodule

>>> hdl/swbm_checker.sv
// Port-level checker of the bitrate meter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module swbm_checker import swbm_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  cfg_psel,
  input logic                  cfg_penable,
  input logic                  cfg_pwrite,
  input logic [CFG_ADDR_W-1:0] cfg_paddr,
  input logic [CFG_DATA_W-1:0] cfg_pwdata,
  input logic [CFG_DATA_W-1:0] cfg_prdata,
  input logic                  cfg_pready
);

  // A stalled result beat stays offered.
  `SWBM_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "out_tvalid dropped while stalled")

  // A stalled result beat keeps its data.
  `SWBM_ASSERT_NXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata), "out_tdata changed while stalled")

  // One beat is worked on at a time: after an accept the input closes.
  `SWBM_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "input accepted a beat while busy")

  // A new result only appears at the end of work on a beat.
  `SWBM_ASSERT_IMP(a_result_after_work, clk, rst_n, $rose(out_tvalid), !$past(in_tready), "result appeared without a beat in work")

  // A write to window_seconds reads back on the next cycle.
  `SWBM_ASSERT_NXT(a_cfg_readback, clk, rst_n, cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && (cfg_paddr[CFG_ADDR_W-1:2] == REG_WINDOW_SECONDS), cfg_prdata[WIN_W-1:0] == $past(cfg_pwdata[WIN_W-1:0]), "window_seconds readback mismatch")

endmodule

bind sliding_window_bitrate_meter swbm_checker u_swbm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata),
  .cfg_pready  (cfg_pready)
);

>>> tb/sliding_window_bitrate_meter_tb.sv
// Self-checking stream testbench for the sliding window bitrate meter.
`timescale 1ns / 1ps

module sliding_window_bitrate_meter_tb;
  import swbm_pkg::*;

  // A run with no beat accepted on any port for this many cycles has hung.
  localparam int STALL_LIMIT = 4000;
  // Cycles left to pass once the output has gone quiet; the worst case is a
  // full ring expiring behind the divider.
  localparam int SETTLE_CYCLES = 150;
  // Enough beats at the largest byte count to saturate one bucket.
  localparam int SAT_BEATS = 260;

  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SECONDS, 2'b00};
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [RATE_W-1:0]  rate_kbps;
    logic [BYTES_W-1:0] window_bytes;
  } meter_result_t;

  // Mirror of the meter: a ring of per-second byte buckets, the running total and
  // the window start, plus the results still owed by the block, oldest first.
  class rate_window_tracker;
    bit [TIME_W-1:0]  bucket_sec [MAX_BUCKETS_DEF];
    bit [BYTES_W-1:0] bucket_sum [MAX_BUCKETS_DEF];
    bit [3:0]         head;
    bit [4:0]         used;
    bit [BYTES_W-1:0] total;
    bit [TIME_W-1:0]  start;
    bit [WIN_W-1:0]   window;
    meter_result_t    owed[$];
    int unsigned      errors;

    function new();
      head   = '0;
      used   = '0;
      total  = '0;
      start  = '0;
      window = WIN_W'(WIN_RESET);
      errors = 0;
    endfunction

    function void set_window(bit [WIN_W-1:0] value);
      window = value;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function bit [BYTES_W-1:0] add_sat(bit [BYTES_W-1:0] a, bit [BYTES_W-1:0] b);
      bit [BYTES_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[BYTES_W] ? '1 : s[BYTES_W-1:0];
    endfunction

    // The oldest bucket leaves the total, which never goes below zero.
    function void drop_oldest();
      total = (total >= bucket_sum[head]) ? total - bucket_sum[head] : '0;
      head  = head + 4'd1;
      used  = used - 5'd1;
    endfunction

    function void record_event(bit [TIME_W-1:0] now, bit [BYTE_IN_W-1:0] count);
      bit [3:0]        newest;
      bit [3:0]        slot;
      bit [TIME_W-1:0] span;
      bit [63:0]       den;
      bit [63:0]       quot;
      meter_result_t   res;
      newest = head + 4'(used - 5'd1);
      // Time running backwards, against the window start or the newest bucket,
      // throws the whole window away.
      if (now < start || (used != 0 && now < bucket_sec[newest])) begin
        used  = '0;
        head  = '0;
        total = '0;
        start = now;
      end
      newest = head + 4'(used - 5'd1);
      total  = add_sat(total, BYTES_W'(count));
      if (used != 0 && bucket_sec[newest] == now) begin
        bucket_sum[newest] = add_sat(bucket_sum[newest], BYTES_W'(count));
      end else begin
        if (used >= 5'(MAX_BUCKETS_DEF)) begin
          drop_oldest();
        end
        slot             = head + 4'(used);
        bucket_sec[slot] = now;
        bucket_sum[slot] = BYTES_W'(count);
        used             = used + 5'd1;
      end
      while (used != 0 && (now - bucket_sec[head]) >= TIME_W'(window)) begin
        drop_oldest();
      end
      if (used != 0) begin
        start = bucket_sec[head];
      end
      res.window_bytes = total;
      res.rate_kbps    = '0;
      if (now > start) begin
        span = now - start;
        den  = 64'(span) * 64'(RATE_DIVISOR);
        quot = (64'(total) * 64'(BITS_PER_BYTE)) / den;
        res.rate_kbps = (quot > 64'(ALL_ONES)) ? ALL_ONES : quot[RATE_W-1:0];
      end
      owed.push_back(res);
    endfunction

    function void check_report(logic [RATE_W-1:0] rate, logic [BYTES_W-1:0] bytes);
      meter_result_t exp_res;
      if (owed.size() == 0) begin
        $error("result beat with nothing owed: rate_kbps %0d, window_bytes %0d", rate, bytes);
        errors++;
        return;
      end
      exp_res = owed.pop_front();
      if (rate !== exp_res.rate_kbps) begin
        $error("rate_kbps mismatch: expected %0d, actual %0d", exp_res.rate_kbps, rate);
        errors++;
      end
      if (bytes !== exp_res.window_bytes) begin
        $error("window_bytes mismatch: expected %0d, actual %0d", exp_res.window_bytes, bytes);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // [31:0] now_seconds, [63:32] byte_count
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // [31:0] rate_kbps, [71:32] window_bytes
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  rate_window_tracker tracker;

  // Percent chance of an idle burst before a beat; the result side turns it into
  // a per-cycle stall chance. Calm mode, for the closing stretch, turns both off.
  int unsigned idle_pct;
  bit          calm;
  logic [31:0] cur_sec;
  int          quiet_cycles = 0;

  sliding_window_bitrate_meter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Byte counts mix packet-sized values and the full 32-bit range in equal shares
  // and keep zero and the largest count in the mix.
  function automatic logic [31:0] pick_bytes();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      2, 3, 4, 5: return $urandom();
      default: return 32'($urandom_range(0, 1500));
    endcase
  endfunction

  // Present one event beat, optionally after an idle burst, and hand it to the
  // tracker at the edge where it is taken.
  task automatic send_event(input logic [31:0] now, input logic [31:0] count);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {count, now};
    do @(posedge clk); while (!in_tready);
    tracker.record_event(now, count);
  endtask

  // Stop sending and wait until every owed result has come back, then a little
  // longer so the block is surely back in its idle state.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle; the upper data bits carry
  // random junk that the block must ignore.
  task automatic write_window(input logic [WIN_W-1:0] value);
    drain();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = WINDOW_ADDR;
    cfg_pwdata  = {(CFG_DATA_W - WIN_W)'($urandom()), value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.set_window(value);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // One window setting's worth of random traffic. Most of it walks time forward
  // in small steps so buckets merge, age and expire; the rest jumps backwards,
  // throws in unrelated noise, or packs distinct seconds to fill the ring.
  task automatic run_phase(input logic [WIN_W-1:0] win, input int n_items,
                           input bit with_sat);
    int          sent;
    int          len;
    int          i;
    logic [31:0] delta;
    logic [31:0] base;
    write_window(win);
    case ($urandom_range(0, 2))
      0:       idle_pct = 0;
      1:       idle_pct = 10;
      default: idle_pct = 35;
    endcase
    sent = 0;
    if (with_sat) begin
      // A bucket driven to saturation, a second bucket behind it, then aging
      // both out: the first leaves the total at zero, so the second one can
      // only be taken off down to the floor.
      base = $urandom_range(0, 32'h7FFF_FFFF);
      for (i = 0; i < SAT_BEATS; i++) send_event(base, ALL_ONES);
      send_event(base + 32'd1, ALL_ONES);
      send_event(base + 32'(win), 32'd0);
      send_event(base + 32'(win) + 32'd1, 32'd0);
      cur_sec = base + 32'(win) + 32'd1;
      sent = SAT_BEATS + 3;
    end
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        7: begin
          cur_sec = cur_sec - 32'($urandom_range(1, 20));
          send_event(cur_sec, pick_bytes());
          sent++;
        end
        8: begin
          len = $urandom_range(1, 4);
          for (i = 0; i < len; i++) begin
            cur_sec = $urandom();
            send_event(cur_sec, $urandom());
          end
          sent += len;
        end
        9: begin
          len = $urandom_range(17, 24);
          for (i = 0; i < len; i++) begin
            cur_sec = cur_sec + 32'd1;
            send_event(cur_sec, pick_bytes());
          end
          sent += len;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       cur_sec = $urandom();
            1:       cur_sec = ALL_ONES - 32'($urandom_range(0, 60));
            default: ;
          endcase
          len = $urandom_range(4, 40);
          for (i = 0; i < len; i++) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5, 6:             delta = 32'd0;
              7, 8, 9, 10, 11, 12, 13, 14:     delta = 32'd1;
              15, 16, 17:                      delta = 32'($urandom_range(2, 4));
              18:                              delta = 32'($urandom_range(0, 2 * win + 2));
              default:                         delta = 32'(win);
            endcase
            cur_sec = cur_sec + delta;
            send_event(cur_sec, pick_bytes());
          end
          sent += len;
        end
      endcase
    end
  endtask

  // Result side: every beat taken is checked against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_report(out_tdata[RATE_W-1:0], out_tdata[RATE_W +: BYTES_W]);
    end
  end

  // Backpressure on the result side: random stall bursts.
  initial begin : result_ready
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 199) < idle_pct) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // Hang detector: any beat on any port restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    tracker      = new();
    idle_pct     = 10;
    calm         = 1'b0;
    cur_sec      = '0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part, at the reset window of 8 seconds. Time zero against a zero
    // window start gives no rate; the largest count merges into that bucket.
    send_event(32'd0, 32'd0);
    send_event(32'd0, ALL_ONES);
    send_event(32'd1, 32'd100);
    send_event(32'd3, ALL_ONES);
    send_event(32'd3, 32'd5);
    // A long jump ages out everything before it.
    send_event(32'd20, 32'd1000);
    // Time falls below the window start and the window is cleared.
    send_event(32'd2, 32'd7);
    // Time falls below the newest bucket while still past the window start.
    send_event(32'd10, 32'd1);
    send_event(32'd12, 32'd1);
    send_event(32'd11, 32'd1);
    // The last second there is, twice.
    send_event(ALL_ONES, ALL_ONES);
    send_event(ALL_ONES, 32'd1);

    // A zero window expires every bucket, the new one too, and the window start
    // stays where it was.
    write_window(5'd0);
    send_event(32'd40, 32'd10);
    send_event(32'd40, 32'd20);
    send_event(32'd41, 32'd5);

    // With the widest window, seventeen distinct seconds overflow the ring and
    // the oldest bucket is pushed out before its time.
    write_window(5'd31);
    for (i = 0; i < 17; i++) send_event(32'd100 + 32'(i), $urandom());
    cur_sec = 32'd116;

    // Random part over a spread of window settings, extremes included.
    run_phase(5'd1, 260, 1'b0);
    run_phase(5'd16, 260, 1'b0);
    run_phase(5'd31, 260, 1'b0);
    run_phase(5'd0, 200, 1'b0);
    run_phase(5'd3, 400, 1'b1);
    run_phase(WIN_W'($urandom_range(2, 15)), 260, 1'b0);
    // Closing stretch runs flat out with no idling on either side.
    calm = 1'b1;
    run_phase(5'd8, 260, 1'b0);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
